// File: src/ssp_pkg.sv
// Shared types and constants for the single-source shortest path block.
// Depends on nothing; every other file refers to it by scoped names.
package ssp_pkg;

	// Default sizing, handed down from the top level as parameter defaults.
	localparam int MAX_NODES_DEF   = 128;
	localparam int WEIGHT_BITS_DEF = 16;

	// Depth of the command queue between the front and the engine.
	localparam int CMD_DEPTH = 4;

	// Largest distance that can be represented; sums saturate here.
	localparam logic [22:0] DIST_MAX = 23'h7FFFFF;

	// Kinds of input item.
	typedef enum logic [1:0] {
		KIND_EDGE  = 2'd0,
		KIND_LAST  = 2'd1,
		KIND_CLOSE = 2'd2,
		KIND_NONE  = 2'd3
	} kind_t;

	// One input item.
	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  node_a;
		logic [7:0]  node_b;
		logic [15:0] edge_weight;
	} in_item_t;

	// One result item.
	typedef struct packed {
		logic        reachable;
		logic [22:0] distance;
	} result_t;

	// A classified command passed from the front to the engine.
	typedef struct packed {
		logic        has_edge;
		logic        close;
		logic [7:0]  node_a;
		logic [7:0]  node_b;
		logic [15:0] edge_weight;
	} cmd_t;

endpackage

// File: src/ssp_front.sv
// Front end: accepts input transactions, classifies them and queues commands.
// Depends on ssp_pkg for the item and command types.
module ssp_front #(
	parameter int MAX_NODES   = ssp_pkg::MAX_NODES_DEF,
	parameter int WEIGHT_BITS = ssp_pkg::WEIGHT_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  ssp_pkg::in_item_t in_item,
	output logic              cmd_valid,
	input  logic              cmd_pop,
	output ssp_pkg::cmd_t     cmd
);

	localparam int QAW = $clog2(ssp_pkg::CMD_DEPTH);
	localparam logic [31:0] WMASK = 32'((64'd1 << WEIGHT_BITS) - 64'd1);

	ssp_pkg::cmd_t    queue_q [ssp_pkg::CMD_DEPTH];
	logic [QAW:0]     wr_ptr_q;
	logic [QAW:0]     rd_ptr_q;
	logic [QAW:0]     count;
	logic             a_ok;
	logic             b_ok;
	logic             w_ok;
	logic             edge_ok;
	logic             is_edge;
	logic             is_close;
	logic             enq;
	ssp_pkg::cmd_t    new_cmd;

	// Classify the incoming item.
	always_comb begin
		is_edge  = (in_item.kind == ssp_pkg::KIND_EDGE);
		is_close = (in_item.kind == ssp_pkg::KIND_LAST) || (in_item.kind == ssp_pkg::KIND_CLOSE);
		a_ok     = (in_item.node_a != 8'd0) && (32'(in_item.node_a) <= 32'(MAX_NODES));
		b_ok     = (in_item.node_b != 8'd0) && (32'(in_item.node_b) <= 32'(MAX_NODES));
		w_ok     = |(32'(in_item.edge_weight) & WMASK);
		edge_ok  = a_ok && b_ok && w_ok &&
			((in_item.kind == ssp_pkg::KIND_EDGE) || (in_item.kind == ssp_pkg::KIND_LAST));
		new_cmd.has_edge    = edge_ok;
		new_cmd.close       = is_close;
		new_cmd.node_a      = in_item.node_a;
		new_cmd.node_b      = in_item.node_b;
		new_cmd.edge_weight = in_item.edge_weight;
		count = wr_ptr_q - rd_ptr_q;
		full  = (count == (QAW+1)'(ssp_pkg::CMD_DEPTH));
		enq   = push && !full && (is_close || (is_edge && edge_ok));
	end

	assign cmd_valid = (count != '0);
	assign cmd       = queue_q[rd_ptr_q[QAW-1:0]];

	// Queue storage.
	always_ff @(posedge clk) begin
		if (enq) begin
			queue_q[wr_ptr_q[QAW-1:0]] <= new_cmd;
		end
	end

	// Queue pointers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			if (enq) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (cmd_pop && cmd_valid) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
		end
	end

endmodule

// File: src/ssp_engine.sv
// Back end: weight store, label-setting search, result register and clearing pass.
// Depends on ssp_pkg for the command and result types and the distance limit.
module ssp_engine #(
	parameter int MAX_NODES   = ssp_pkg::MAX_NODES_DEF,
	parameter int WEIGHT_BITS = ssp_pkg::WEIGHT_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	output logic             cmd_pop,
	input  ssp_pkg::cmd_t    cmd,
	input  logic [7:0]       node_count,
	output logic             empty,
	input  logic             pop,
	output ssp_pkg::result_t result
);

	localparam int NB     = $clog2(MAX_NODES);
	localparam int AW     = 2 * NB;
	localparam int DDEPTH = 1 << NB;
	localparam int SW     = ((WEIGHT_BITS > 23) ? WEIGHT_BITS : 23) + 1;

	typedef enum logic [6:0] {
		ST_CLEAR  = 7'b0000001,
		ST_IDLE   = 7'b0000010,
		ST_INIT   = 7'b0000100,
		ST_SEL    = 7'b0001000,
		ST_RELAX  = 7'b0010000,
		ST_TARGET = 7'b0100000,
		ST_RESULT = 7'b1000000
	} state_t;

	state_t state_q;

	// Memories and their ports.
	logic [WEIGHT_BITS-1:0] wmem [1 << AW];
	logic [22:0]            dmem [DDEPTH];
	logic                   w_we;
	logic [AW-1:0]          w_waddr;
	logic [WEIGHT_BITS-1:0] w_wdata;
	logic [AW-1:0]          w_raddr;
	logic [WEIGHT_BITS-1:0] w_rdata_q;
	logic                   d_we;
	logic [NB-1:0]          d_waddr;
	logic [22:0]            d_wdata;
	logic [NB-1:0]          d_raddr;
	logic [22:0]            d_rdata_q;

	// Edge store stage.
	logic                   e_valid_s1;
	logic                   e_edge_s1;
	logic                   e_close_s1;
	logic [AW-1:0]          e_addr_s1;
	logic [WEIGHT_BITS-1:0] e_w_s1;
	logic                   last_we_q;
	logic [AW-1:0]          last_addr_q;
	logic [WEIGHT_BITS-1:0] last_w_q;

	// Search state.
	logic [DDEPTH-1:0]      vis_q;
	logic [DDEPTH-1:0]      pend_q;
	logic [NB:0]            cnt_q;
	logic                   rd_valid_s1;
	logic [NB-1:0]          rd_idx_s1;
	logic                   found_q;
	logic [22:0]            best_q;
	logic [NB-1:0]          bidx_q;
	logic [22:0]            du_q;
	logic [NB-1:0]          u_q;
	logic [AW-1:0]          clr_q;
	logic                   out_valid_q;
	ssp_pkg::result_t       out_q;

	// Combinational helpers.
	logic [7:0]             am1;
	logic [7:0]             bm1;
	logic [NB-1:0]          ia;
	logic [NB-1:0]          ib;
	logic [AW-1:0]          cmd_addr;
	logic [WEIGHT_BITS-1:0] cmd_w;
	logic [WEIGHT_BITS-1:0] cur_w;
	logic                   issue;
	logic [NB-1:0]          kidx;
	logic                   cand;
	logic                   last_idx;
	logic                   nfound;
	logic [22:0]            nbest;
	logic [NB-1:0]          nidx;
	logic [SW-1:0]          sum;
	logic [22:0]            nd;
	logic                   relax_upd;
	logic                   tgt_ok;
	logic [NB-1:0]          tidx;

	// Address and value decoding for the command at the head of the queue.
	always_comb begin
		am1      = cmd.node_a - 8'd1;
		bm1      = cmd.node_b - 8'd1;
		ia       = NB'(am1);
		ib       = NB'(bm1);
		cmd_addr = (ia < ib) ? {ia, ib} : {ib, ia};
		cmd_w    = WEIGHT_BITS'(32'(cmd.edge_weight));
		cur_w    = (last_we_q && (last_addr_q == e_addr_s1)) ? last_w_q : w_rdata_q;
		cmd_pop  = (state_q == ST_IDLE) && cmd_valid && !(e_valid_s1 && e_close_s1);
		tgt_ok   = (node_count != 8'd0) && (32'(node_count) <= 32'(MAX_NODES));
		tidx     = NB'(node_count - 8'd1);
	end

	// Search datapath: candidate selection and saturating relaxation.
	always_comb begin
		issue    = (32'(cnt_q) < 32'(MAX_NODES));
		kidx     = cnt_q[NB-1:0];
		last_idx = (rd_idx_s1 == NB'(MAX_NODES - 1));
		cand     = pend_q[rd_idx_s1] && !vis_q[rd_idx_s1] && (!found_q || (d_rdata_q < best_q));
		nfound   = found_q || cand;
		nbest    = cand ? d_rdata_q : best_q;
		nidx     = cand ? rd_idx_s1 : bidx_q;
		sum      = SW'(du_q) + SW'(w_rdata_q);
		nd       = (sum > SW'(ssp_pkg::DIST_MAX)) ? ssp_pkg::DIST_MAX : sum[22:0];
		relax_upd = (w_rdata_q != '0) && !vis_q[rd_idx_s1] &&
			(!pend_q[rd_idx_s1] || (nd < d_rdata_q));
	end

	// Memory port selection.
	always_comb begin
		w_we    = 1'b0;
		w_waddr = e_addr_s1;
		w_wdata = e_w_s1;
		w_raddr = cmd_addr;
		d_we    = 1'b0;
		d_waddr = rd_idx_s1;
		d_wdata = nd;
		d_raddr = kidx;
		case (state_q)
			ST_CLEAR: begin
				w_we    = 1'b1;
				w_waddr = clr_q;
				w_wdata = '0;
			end
			ST_IDLE: begin
				w_we = e_valid_s1 && e_edge_s1 && ((cur_w == '0) || (e_w_s1 < cur_w));
			end
			ST_INIT: begin
				d_we    = 1'b1;
				d_waddr = '0;
				d_wdata = '0;
			end
			ST_RELAX: begin
				w_raddr = (u_q < kidx) ? {u_q, kidx} : {kidx, u_q};
				d_we    = rd_valid_s1 && relax_upd;
			end
			ST_TARGET, ST_RESULT: begin
				d_raddr = tidx;
			end
			default: begin
			end
		endcase
	end

	// Weight store.
	always_ff @(posedge clk) begin
		if (w_we) begin
			wmem[w_waddr] <= w_wdata;
		end
		w_rdata_q <= wmem[w_raddr];
	end

	// Distance store.
	always_ff @(posedge clk) begin
		if (d_we) begin
			dmem[d_waddr] <= d_wdata;
		end
		d_rdata_q <= dmem[d_raddr];
	end

	// Payload registers of the edge stage.
	always_ff @(posedge clk) begin
		e_addr_s1   <= cmd_addr;
		e_w_s1      <= cmd_w;
		e_edge_s1   <= cmd.has_edge;
		e_close_s1  <= cmd.close;
		last_addr_q <= w_waddr;
		last_w_q    <= w_wdata;
	end

	// Sequencer and search control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			e_valid_s1  <= 1'b0;
			last_we_q   <= 1'b0;
			vis_q       <= '0;
			pend_q      <= '0;
			cnt_q       <= '0;
			rd_valid_s1 <= 1'b0;
			rd_idx_s1   <= '0;
			found_q     <= 1'b0;
			best_q      <= '0;
			bidx_q      <= '0;
			du_q        <= '0;
			u_q         <= '0;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			e_valid_s1 <= cmd_pop;
			last_we_q  <= w_we && (state_q == ST_IDLE);
			if (pop && out_valid_q) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == '1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (e_valid_s1 && e_close_s1) begin
						state_q <= ST_INIT;
					end
				end
				ST_INIT: begin
					vis_q       <= '0;
					pend_q      <= DDEPTH'(1);
					cnt_q       <= '0;
					found_q     <= 1'b0;
					rd_valid_s1 <= 1'b0;
					state_q     <= ST_SEL;
				end
				ST_SEL: begin
					// Once the last index has been issued no further read is issued, so none is pending when it returns.
					rd_valid_s1 <= issue;
					rd_idx_s1   <= kidx;
					if (issue) begin
						cnt_q <= cnt_q + 1'b1;
					end
					if (rd_valid_s1) begin
						found_q <= nfound;
						best_q  <= nbest;
						bidx_q  <= nidx;
						if (last_idx) begin
							cnt_q <= '0;
							if (nfound) begin
								vis_q[nidx]  <= 1'b1;
								pend_q[nidx] <= 1'b0;
								du_q         <= nbest;
								u_q          <= nidx;
								state_q      <= ST_RELAX;
							end else begin
								state_q <= ST_TARGET;
							end
						end
					end
				end
				ST_RELAX: begin
					rd_valid_s1 <= issue;
					rd_idx_s1   <= kidx;
					if (issue) begin
						cnt_q <= cnt_q + 1'b1;
					end
					if (rd_valid_s1) begin
						if (relax_upd) begin
							pend_q[rd_idx_s1] <= 1'b1;
						end
						if (last_idx) begin
							cnt_q   <= '0;
							found_q <= 1'b0;
							state_q <= ST_SEL;
						end
					end
				end
				ST_TARGET: begin
					state_q <= ST_RESULT;
				end
				ST_RESULT: begin
					if (!out_valid_q) begin
						out_valid_q <= 1'b1;
						if (tgt_ok && vis_q[tidx]) begin
							out_q.reachable <= 1'b1;
							out_q.distance  <= d_rdata_q;
						end else begin
							out_q.reachable <= 1'b0;
							out_q.distance  <= '0;
						end
						clr_q   <= '0;
						state_q <= ST_CLEAR;
					end
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
		end
	end

	assign empty  = !out_valid_q;
	assign result = out_q;

endmodule

// File: src/single_source_shortest_path.sv
// Single-source shortest path block: a queue-like front end feeding the search engine.
// Depends on ssp_pkg, ssp_front and ssp_engine.
//
// Edge transactions are taken one per clock while the command queue is not full and stored
// into a triangular weight memory, keeping the smaller weight for a repeated pair. A closing
// transaction starts a search from node 1 to node node_count: each round scans all MAX_NODES
// distances for the nearest open node and then relaxes its row, through the single read port
// of the weight and distance memories. There is one round per node reached plus a final empty
// one. After the result is registered, and once after reset, a clearing pass writes zero to
// every weight entry, one entry a cycle, 2**(2*ceil(log2(MAX_NODES))) entries (16384 at the
// default size); no edge is stored during it, though the four-entry command queue keeps
// accepting until full. node_count is written through cfg_valid/cfg_data, which is always
// ready; the user must write it only while idle, as the block itself does not enforce this.
module single_source_shortest_path #(
	parameter int MAX_NODES   = ssp_pkg::MAX_NODES_DEF,
	parameter int WEIGHT_BITS = ssp_pkg::WEIGHT_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  ssp_pkg::in_item_t in_item,
	output logic              empty,
	input  logic              pop,
	output ssp_pkg::result_t  result,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [7:0]        cfg_data
);

	logic          cmd_valid;
	logic          cmd_pop;
	ssp_pkg::cmd_t cmd;
	logic [7:0]    node_count_q;

	// Configuration register.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= 8'd1;
		end else if (cfg_valid && cfg_ready) begin
			node_count_q <= cfg_data;
		end
	end

	// Front end and command queue.
	ssp_front #(
		.MAX_NODES   (MAX_NODES),
		.WEIGHT_BITS (WEIGHT_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.in_item   (in_item),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop),
		.cmd       (cmd)
	);

	// Search engine and result register.
	ssp_engine #(
		.MAX_NODES   (MAX_NODES),
		.WEIGHT_BITS (WEIGHT_BITS)
	) u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_pop    (cmd_pop),
		.cmd        (cmd),
		.node_count (node_count_q),
		.empty      (empty),
		.pop        (pop),
		.result     (result)
	);

endmodule

// File: tb/path_scoreboard.sv
// Scoreboard for the single-source shortest path block: edge store, search and result check.
// Depends on ssp_pkg for the transaction types and the saturation limit.
class path_scoreboard;
	localparam int NODES = 128;

	bit [15:0]           weights [NODES][NODES];
	bit [7:0]            target;
	ssp_pkg::result_t    awaited [$];
	int                  errors;

	function new();
		target = 8'd1;
		errors = 0;
		wipe_weights();
	endfunction

	function void wipe_weights();
		foreach (weights[i, j]) weights[i][j] = '0;
	endfunction

	function void set_target(bit [7:0] value);
		target = value;
	endfunction

	// Keeps the lighter of a repeated edge; bad endpoints and zero weights are dropped.
	function void store_edge(bit [7:0] a, bit [7:0] b, bit [15:0] w);
		if (a < 1 || a > NODES || b < 1 || b > NODES || w == 0)
			return;
		if (weights[a-1][b-1] == 0 || w < weights[a-1][b-1]) begin
			weights[a-1][b-1] = w;
			weights[b-1][a-1] = w;
		end
	endfunction

	// Label-setting search from node 1; sums saturate at the largest distance.
	function ssp_pkg::result_t shortest_to_target();
		bit [22:0]        cost [NODES];
		bit               done [NODES];
		bit               open [NODES];
		bit               found;
		int               u;
		longint unsigned  sum;
		bit [22:0]        d;
		ssp_pkg::result_t res;
		foreach (cost[i]) begin
			cost[i] = '0;
			done[i] = 1'b0;
			open[i] = 1'b0;
		end
		open[0] = 1'b1;
		forever begin
			found = 1'b0;
			u = 0;
			for (int i = 0; i < NODES; i++)
				if (open[i] && !done[i] && (!found || cost[i] < cost[u])) begin
					u = i;
					found = 1'b1;
				end
			if (!found)
				break;
			done[u] = 1'b1;
			open[u] = 1'b0;
			for (int k = 0; k < NODES; k++) begin
				if (weights[u][k] == 0 || done[k])
					continue;
				sum = longint'(cost[u]) + longint'(weights[u][k]);
				d = (sum > ssp_pkg::DIST_MAX) ? ssp_pkg::DIST_MAX : sum[22:0];
				if (!open[k] || d < cost[k]) begin
					cost[k] = d;
					open[k] = 1'b1;
				end
			end
		end
		res = '0;
		if (target >= 1 && target <= NODES && done[target-1]) begin
			res.reachable = 1'b1;
			res.distance  = cost[target-1];
		end
		return res;
	endfunction

	// Notes one accepted input transaction and queues any result it causes.
	function void note_item(ssp_pkg::in_item_t it);
		ssp_pkg::kind_t k;
		k = ssp_pkg::kind_t'(it.kind);
		if (k == ssp_pkg::KIND_NONE)
			return;
		if (k == ssp_pkg::KIND_EDGE || k == ssp_pkg::KIND_LAST)
			store_edge(it.node_a, it.node_b, it.edge_weight);
		if (k == ssp_pkg::KIND_EDGE)
			return;
		awaited.insert(awaited.size(), shortest_to_target());
		wipe_weights();
	endfunction

	task report_mismatch(string msg);
		$display("MISMATCH at %0t: %s", $realtime, msg);
		errors++;
	endtask

	// Compares one accepted result transaction with the oldest awaited one.
	task check_result(ssp_pkg::result_t got);
		ssp_pkg::result_t want;
		if (awaited.size() == 0) begin
			report_mismatch($sformatf("unexpected result %0b/%0d", got.reachable,
				got.distance));
			return;
		end
		want = awaited.pop_front();
		if (got.reachable !== want.reachable)
			report_mismatch($sformatf("reachable %0b, expected %0b", got.reachable,
				want.reachable));
		if (got.distance !== want.distance)
			report_mismatch($sformatf("distance %0d, expected %0d", got.distance,
				want.distance));
	endtask
endclass

// File: tb/single_source_shortest_path_tb.sv
// Top-level testbench for single_source_shortest_path: clock, reset, drivers and monitor.
// Depends on ssp_pkg, the block itself and the class in path_scoreboard.sv.
module single_source_shortest_path_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDLE_LIMIT   = 200000;
	localparam int SETTLE_WAIT  = 50000;
	localparam int ITEM_TARGET  = 550;
	localparam int QUIET_FROM   = 490;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              push = 1'b0;
	logic              full;
	ssp_pkg::in_item_t in_item = '0;
	logic              empty;
	logic              pop = 1'b0;
	ssp_pkg::result_t  result;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [7:0]        cfg_data = 8'd0;

	path_scoreboard board = new();
	bit quiet = 1'b0;
	int items_sent = 0;
	int results_seen = 0;
	int idle_cycles = 0;

	single_source_shortest_path dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .in_item(in_item),
		.empty(empty), .pop(pop), .result(result),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	// Monitor: every transaction is taken at the rising edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full)
				board.note_item(in_item);
			if (pop && !empty) begin
				board.check_result(result);
				results_seen++;
			end
			if (cfg_valid && cfg_ready)
				board.set_target(cfg_data);
			if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("watchdog expired at %0t", $realtime);
				$display("single_source_shortest_path test failed");
				$finish;
			end
		end
	end

	// Result side: pop in random bursts, steady once the run goes quiet.
	initial begin
		forever begin
			@(negedge clk);
			if (!quiet && $urandom_range(3) == 0) begin
				pop = 1'b0;
				repeat ($urandom_range(1, 18)) @(negedge clk);
			end else begin
				pop = 1'b1;
				repeat ($urandom_range(1, 30)) @(negedge clk);
			end
		end
	end

	// Offers one input transaction from a falling edge until it is taken.
	task send_item(bit [1:0] kind, bit [7:0] a, bit [7:0] b, bit [15:0] w);
		if (!quiet && $urandom_range(3) == 0) begin
			push = 1'b0;
			repeat ($urandom_range(1, 18)) @(negedge clk);
		end
		push = 1'b1;
		in_item = '{kind: kind, node_a: a, node_b: b, edge_weight: w};
		while (full) @(negedge clk);
		@(negedge clk);
		items_sent++;
		if (items_sent >= QUIET_FROM)
			quiet = 1'b1;
	endtask

	// Waits for every result, lets the clearing pass finish, then sets node_count.
	task set_node_count(bit [7:0] value);
		push = 1'b0;
		while (board.awaited.size() != 0) @(negedge clk);
		repeat (SETTLE_WAIT) @(negedge clk);
		cfg_valid = 1'b1;
		cfg_data = value;
		while (!cfg_ready) @(negedge clk);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function bit [7:0] pick_node(int span);
		if ($urandom_range(9) == 0)
			return 8'($urandom_range(0, 255));
		return 8'($urandom_range(1, span));
	endfunction

	function bit [15:0] pick_weight();
		case ($urandom_range(9))
			0:       return 16'd0;
			1:       return 16'hFFFF;
			2, 3:    return 16'($urandom_range(1, 65535));
			default: return 16'($urandom_range(1, 20));
		endcase
	endfunction

	// One random case: loose edges, sometimes a chain from node 1 to node span.
	task random_case(bit [7:0] nc);
		int span;
		int n;
		bit [7:0] prev, next;
		span = (nc >= 2 && nc <= 128) ? nc : 16;
		n = $urandom_range(0, 14);
		if ($urandom_range(1) == 0) begin
			prev = 8'd1;
			for (int i = 0; i < $urandom_range(1, 6); i++) begin
				next = 8'($urandom_range(1, span));
				send_item(ssp_pkg::KIND_EDGE, prev, next, pick_weight());
				prev = next;
			end
			send_item(ssp_pkg::KIND_EDGE, prev, 8'(span), pick_weight());
		end
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(19) == 0)
				send_item(ssp_pkg::KIND_NONE, pick_node(span), pick_node(span),
					pick_weight());
			send_item(ssp_pkg::KIND_EDGE, pick_node(span), pick_node(span), pick_weight());
		end
		if ($urandom_range(1) == 0)
			send_item(ssp_pkg::KIND_LAST, pick_node(span), pick_node(span), pick_weight());
		else
			send_item(ssp_pkg::KIND_CLOSE, 8'($urandom), 8'($urandom), 16'($urandom));
	endtask

	initial begin
		bit [7:0] targets [8] = '{8'd128, 8'd1, 8'd0, 8'd255, 8'd2, 8'd129, 8'd9, 8'd40};
		int phase;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		// Directed part: five nodes, with the special edges of the store.
		set_node_count(8'd5);
		send_item(ssp_pkg::KIND_EDGE, 8'd1, 8'd2, 16'hFFFF);
		send_item(ssp_pkg::KIND_EDGE, 8'd2, 8'd5, 16'd1);
		send_item(ssp_pkg::KIND_EDGE, 8'd2, 8'd1, 16'd3);
		send_item(ssp_pkg::KIND_EDGE, 8'd1, 8'd2, 16'd100);
		send_item(ssp_pkg::KIND_EDGE, 8'd5, 8'd5, 16'd1);
		send_item(ssp_pkg::KIND_EDGE, 8'd1, 8'd5, 16'd0);
		send_item(ssp_pkg::KIND_EDGE, 8'd0, 8'd5, 16'd1);
		send_item(ssp_pkg::KIND_EDGE, 8'd1, 8'd129, 16'd1);
		send_item(ssp_pkg::KIND_EDGE, 8'd255, 8'd255, 16'hFFFF);
		send_item(ssp_pkg::KIND_NONE, 8'd1, 8'd5, 16'd1);
		send_item(ssp_pkg::KIND_LAST, 8'd5, 8'd2, 16'd2);
		send_item(ssp_pkg::KIND_CLOSE, 8'd0, 8'd0, 16'd0);
		send_item(ssp_pkg::KIND_EDGE, 8'd1, 8'd7, 16'd1);
		send_item(ssp_pkg::KIND_LAST, 8'd7, 8'd5, 16'd1);
		send_item(ssp_pkg::KIND_LAST, 8'd0, 8'd1, 16'd4);
		send_item(ssp_pkg::KIND_EDGE, 8'd1, 8'd3, 16'hFFFF);
		send_item(ssp_pkg::KIND_EDGE, 8'd3, 8'd4, 16'hFFFF);
		send_item(ssp_pkg::KIND_LAST, 8'd4, 8'd5, 16'hFFFF);

		// Random part: a few cases under each node_count setting.
		phase = 0;
		while (items_sent < ITEM_TARGET) begin
			if (phase < 8)
				set_node_count(targets[phase]);
			else if (!quiet)
				set_node_count(8'($urandom_range(2, 20)));
			phase++;
			repeat ($urandom_range(4, 7))
				random_case((phase <= 8) ? targets[phase-1] : board.target);
		end
		push = 1'b0;

		while (board.awaited.size() != 0) @(negedge clk);
		repeat (200) @(negedge clk);
		if (board.errors == 0)
			$display("single_source_shortest_path test passed");
		else
			$display("single_source_shortest_path test failed");
		$finish;
	end
endmodule
